// ----- src/ots_pkg.sv -----
package ots_pkg;

    // Store geometry.
    localparam int STACK_DEPTH = 16;
    localparam int OWNER_BITS  = 22;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Fixed field widths of the words on the channels.
    localparam int OWNER_IN_W  = 22;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = OWNER_BITS + VALUE_W;

    // Opcodes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Microprogram addresses.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] U_WAIT     = 4'd0;
    localparam logic [STEP_W-1:0] U_INIT     = 4'd1;
    localparam logic [STEP_W-1:0] U_SCAN     = 4'd2;
    localparam logic [STEP_W-1:0] U_RESOLVE  = 4'd3;
    localparam logic [STEP_W-1:0] U_NOTFOUND = 4'd4;
    localparam logic [STEP_W-1:0] U_SHIFT    = 4'd5;
    localparam logic [STEP_W-1:0] U_POPDONE  = 4'd6;
    localparam logic [STEP_W-1:0] U_PUSH     = 4'd7;
    localparam logic [STEP_W-1:0] U_PUSH_WR  = 4'd8;
    localparam logic [STEP_W-1:0] U_FULL     = 4'd9;
    localparam logic [STEP_W-1:0] U_FINISH   = 4'd10;
    localparam logic [STEP_W-1:0] U_STALL    = 4'd11;

    // Datapath action of one step.
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_INIT,
        A_SCAN,
        A_SHIFT,
        A_POP_DONE,
        A_PUSH_WR,
        A_SET_NF,
        A_SET_FULL,
        A_FINISH
    } t_act;

    // Branch condition of one step; the branch goes to the target when true.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_ITEM,
        C_IS_PUSH,
        C_SCAN_MORE,
        C_HIT,
        C_SHIFT_MORE,
        C_FULL,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Control store.
    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            U_WAIT:     w = '{act: A_ACCEPT,   cond: C_NO_ITEM,    target: U_WAIT};
            U_INIT:     w = '{act: A_INIT,     cond: C_IS_PUSH,    target: U_PUSH};
            U_SCAN:     w = '{act: A_SCAN,     cond: C_SCAN_MORE,  target: U_SCAN};
            U_RESOLVE:  w = '{act: A_NONE,     cond: C_HIT,        target: U_SHIFT};
            U_NOTFOUND: w = '{act: A_SET_NF,   cond: C_ALWAYS,     target: U_FINISH};
            U_SHIFT:    w = '{act: A_SHIFT,    cond: C_SHIFT_MORE, target: U_SHIFT};
            U_POPDONE:  w = '{act: A_POP_DONE, cond: C_ALWAYS,     target: U_FINISH};
            U_PUSH:     w = '{act: A_NONE,     cond: C_FULL,       target: U_FULL};
            U_PUSH_WR:  w = '{act: A_PUSH_WR,  cond: C_ALWAYS,     target: U_FINISH};
            U_FULL:     w = '{act: A_SET_FULL, cond: C_ALWAYS,     target: U_FINISH};
            U_FINISH:   w = '{act: A_FINISH,   cond: C_OUT_FREE,   target: U_WAIT};
            U_STALL:    w = '{act: A_NONE,     cond: C_ALWAYS,     target: U_FINISH};
            default:    w = '{act: A_NONE,     cond: C_ALWAYS,     target: U_WAIT};
        endcase
        return w;
    endfunction

    // Keep only the low OWNER_BITS bits of the requester id.
    function automatic logic [OWNER_BITS-1:0] to_tag(input logic [OWNER_IN_W-1:0] id);
        logic [31:0] wide;
        wide = 32'(id);
        return wide[OWNER_BITS-1:0];
    endfunction

endpackage

// ----- src/ots_in_if.sv -----
interface ots_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [ots_pkg::OWNER_IN_W-1:0] owner_id;
    logic [ots_pkg::VALUE_W-1:0]    push_value;

    modport source (output valid, output opcode, output owner_id, output push_value,
                    input ready);
    modport sink   (input valid, input opcode, input owner_id, input push_value,
                    output ready);
endinterface

// ----- src/ots_out_if.sv -----
interface ots_out_if;
    logic                          valid;
    logic                          ready;
    logic [ots_pkg::VALUE_W-1:0]   pop_value;
    logic [ots_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// ----- src/owner_tagged_shared_stack.sv -----
// Shared LIFO store of (owner, value) entries with one result word per input word.
// A push puts the pair on top, or reports full and drops it; a pop removes the newest
// entry of the given owner, closes the gap so the order of the rest is kept, and
// returns its value, or reports not found. Control runs from a microprogram over a
// single-port-write, single-port-read entry RAM with registered read, so entries
// are visited one at a time. A pop searches from the newest entry down to the hit
// or to slot 0 (the oldest), then moves each entry above the hit one slot lower.
// The next word is taken while the last result still waits in the output register.
module owner_tagged_shared_stack (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ots_in_if.sink    i_in,
    ots_out_if.source o_out
);

    localparam int AW = ots_pkg::ADDR_W;
    localparam int CW = ots_pkg::CNT_W;
    localparam int OW = ots_pkg::OWNER_BITS;
    localparam int VW = ots_pkg::VALUE_W;

    ots_pkg::t_uword uw;

    // Sequencer and control state.
    logic [ots_pkg::STEP_W-1:0] r_step, n_step;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic [CW-1:0]              r_src, n_src;
    logic                       r_rd_vld, n_rd_vld;
    logic                       r_hit, n_hit;
    logic                       r_out_valid, n_out_valid;

    // Latched request and pending result.
    logic                          r_op, n_op;
    logic [OW-1:0]                 r_tag, n_tag;
    logic [VW-1:0]                 r_val, n_val;
    logic [VW-1:0]                 r_res_val, n_res_val;
    logic [ots_pkg::STATUS_W-1:0]  r_res_st, n_res_st;
    logic [VW-1:0]                 r_out_val, n_out_val;
    logic [ots_pkg::STATUS_W-1:0]  r_out_st, n_out_st;

    // Entry RAM port.
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [ots_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

    logic          take;
    logic          hit;
    logic          scan_issue;
    logic          shift_issue;
    logic          out_free;
    logic          accept;
    logic [CW-1:0] ptr_dec;

    ots_ram #(
        .WIDTH (ots_pkg::ENTRY_W),
        .DEPTH (ots_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign uw = ots_pkg::uc_rom(r_step);

    // Handshake and status terms used by the branch conditions.
    assign i_in.ready  = i_rst_n && (uw.act == ots_pkg::A_ACCEPT);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign hit         = r_rd_vld && (ram_rdata[ots_pkg::ENTRY_W-1:VW] == r_tag);
    assign scan_issue  = !hit && (r_ptr != '0);
    assign shift_issue = (r_src < r_cnt);
    assign ptr_dec     = r_ptr - CW'(1);

    // Branch condition.
    always_comb begin
        unique case (uw.cond)
            ots_pkg::C_ALWAYS:     take = 1'b1;
            ots_pkg::C_NO_ITEM:    take = !accept;
            ots_pkg::C_IS_PUSH:    take = (r_op == ots_pkg::OP_PUSH);
            ots_pkg::C_SCAN_MORE:  take = scan_issue;
            ots_pkg::C_HIT:        take = r_hit;
            ots_pkg::C_SHIFT_MORE: take = shift_issue;
            ots_pkg::C_FULL:       take = (r_cnt == CW'(ots_pkg::STACK_DEPTH));
            ots_pkg::C_OUT_FREE:   take = out_free;
            default:               take = 1'b1;
        endcase
    end

    // Datapath driven by the current control word.
    always_comb begin
        n_step      = take ? uw.target : ots_pkg::STEP_W'(r_step + 1'b1);
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_src       = r_src;
        n_rd_vld    = r_rd_vld;
        n_hit       = r_hit;
        n_op        = r_op;
        n_tag       = r_tag;
        n_val       = r_val;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;
        n_out_val   = r_out_val;
        n_out_st    = r_out_st;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_ptr[AW-1:0];
        ram_raddr   = ptr_dec[AW-1:0];
        ram_wdata   = ram_rdata;

        // A result leaves when the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (uw.act)
            ots_pkg::A_ACCEPT: begin
                if (accept) begin
                    n_op  = i_in.opcode;
                    n_tag = ots_pkg::to_tag(i_in.owner_id);
                    n_val = i_in.push_value;
                end
            end
            ots_pkg::A_INIT: begin
                n_ptr    = r_cnt;
                n_rd_vld = 1'b0;
                n_hit    = 1'b0;
            end
            ots_pkg::A_SCAN: begin
                // Compare the entry read last cycle while reading the next older one.
                ram_re   = scan_issue;
                n_rd_vld = scan_issue;
                n_hit    = hit;
                if (scan_issue) begin
                    n_ptr = ptr_dec;
                end
                if (hit) begin
                    n_res_val = ram_rdata[VW-1:0];
                    n_src     = CW'(r_ptr + 1'b1);
                end
            end
            ots_pkg::A_SHIFT: begin
                // Read slot src and write what was read last cycle one slot lower.
                ram_re    = shift_issue;
                ram_raddr = r_src[AW-1:0];
                n_rd_vld  = shift_issue;
                if (shift_issue) begin
                    n_src = CW'(r_src + 1'b1);
                end
                if (r_rd_vld) begin
                    ram_we = 1'b1;
                    n_ptr  = CW'(r_ptr + 1'b1);
                end
            end
            ots_pkg::A_POP_DONE: begin
                n_cnt    = r_cnt - CW'(1);
                n_res_st = ots_pkg::ST_OK;
            end
            ots_pkg::A_PUSH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = {r_tag, r_val};
                n_cnt     = CW'(r_cnt + 1'b1);
                n_res_val = '0;
                n_res_st  = ots_pkg::ST_OK;
            end
            ots_pkg::A_SET_NF: begin
                n_res_val = '0;
                n_res_st  = ots_pkg::ST_NOT_FOUND;
            end
            ots_pkg::A_SET_FULL: begin
                n_res_val = '0;
                n_res_st  = ots_pkg::ST_FULL;
            end
            ots_pkg::A_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res_val;
                    n_out_st    = r_res_st;
                end
            end
            default: begin
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ots_pkg::U_WAIT;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
        r_ptr     <= n_ptr;
        r_src     <= n_src;
        r_op      <= n_op;
        r_tag     <= n_tag;
        r_val     <= n_val;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_out_val <= n_out_val;
        r_out_st  <= n_out_st;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pop_value = r_out_val;
    assign o_out.status    = r_out_st;

endmodule

// ----- src/ots_ram.sv -----
module ots_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
